FILE: design/act_pkg.sv
// shared constants, types and table functions for the accelerometer tilt unit
`timescale 1ns / 1ps
package act_pkg;

  localparam int PRE_SHIFT    = 30;
  localparam int CORDIC_ITERS = 40;
  localparam int ACC_W        = 64;
  localparam int COEF_W       = 16;
  localparam int ROLL_W       = 15;
  localparam int PITCH_W      = 14;
  localparam int ROLL_LIM     = 11522;
  localparam int PITCH_LIM    = 5761;
  localparam int UNITS_MUL    = 36672;
  localparam int DIV5_MUL     = 52429;
  localparam int DIV5_SHIFT   = 18;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;
  localparam logic signed [63:0] HPI_Q60  = 64'sh1921FB54442D1846;
  localparam logic signed [63:0] QPI_Q60  = 64'sh0C90FDAA22168C23;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t BIAS [3] = '{-16'sd28, -16'sd160, -16'sd134};
  localparam coef_t MAT [3][3] = '{
    '{16'sd16155, 16'sd147,   16'sd197},
    '{-16'sd82,   16'sd16466, -16'sd98},
    '{16'sd164,   -16'sd16,   16'sd16695}
  };

  // restoring divider, used by atan_q60 to build the angle table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in radians q60, alternating series summed in q62
  function automatic logic signed [63:0] atan_q60(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    sum = '0;
    if (i == 0) return QPI_Q60;
    for (int k = 0; k < 64; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = udiv64(64'd1 << e, 64'(2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return signed'((sum + 64'd2) >> 2);
  endfunction

endpackage

FILE: design/act_cal.sv
// bias removal, matrix correction, rounding and saturation, three stages
`timescale 1ns / 1ps
module act_cal
  import act_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_x,
  input  logic signed [SAMPLE_BITS-1:0] in_y,
  input  logic signed [SAMPLE_BITS-1:0] in_z,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_x,
  output logic signed [SAMPLE_BITS-1:0] out_y,
  output logic signed [SAMPLE_BITS-1:0] out_z
);

  localparam int UW = SAMPLE_BITS + 1;
  localparam int PW = UW + COEF_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HI = SW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic [2:0] vld;
  logic signed [UW-1:0] u [3];
  logic signed [PW-1:0] p [3][3];
  logic signed [SAMPLE_BITS-1:0] c [3];
  logic signed [SW-1:0] s [3];
  logic signed [SW-1:0] sh [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s[i] = SW'(p[i][0]) + SW'(p[i][1]) + SW'(p[i][2]) + SW'(8192);
      sh[i] = s[i] >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= UW'(in_x) - UW'(BIAS[0]);
      u[1] <= UW'(in_y) - UW'(BIAS[1]);
      u[2] <= UW'(in_z) - UW'(BIAS[2]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= PW'(u[j]) * PW'(MAT[i][j]);
        end
        if (sh[i] > HI) c[i] <= HI[SAMPLE_BITS-1:0];
        else if (sh[i] < LO) c[i] <= LO[SAMPLE_BITS-1:0];
        else c[i] <= sh[i][SAMPLE_BITS-1:0];
      end
    end
  end

  assign out_valid = vld[2];
  assign out_x = c[0];
  assign out_y = c[1];
  assign out_z = c[2];

endmodule

FILE: design/act_cordic.sv
// vectoring cordic, quadrant fold then one registered stage per iteration
`timescale 1ns / 1ps
module act_cordic
  import act_pkg::*;
#(
  parameter int XW = 50,
  parameter int SW = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [ACC_W-1:0] out_acc,
  output logic signed [XW-1:0] out_mag,
  output logic [SW-1:0]        out_side
);

  logic                    vld  [CORDIC_ITERS+1];
  logic                    zero [CORDIC_ITERS+1];
  logic signed [XW-1:0]    x    [CORDIC_ITERS+1];
  logic signed [XW-1:0]    y    [CORDIC_ITERS+1];
  logic signed [ACC_W-1:0] acc  [CORDIC_ITERS+1];
  logic [SW-1:0]           side [CORDIC_ITERS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (in_x == '0) && (in_y == '0);
      side[0] <= in_side;
      if (in_x < 0) begin
        if (in_y >= 0) begin
          x[0] <= in_y;
          y[0] <= -in_x;
          acc[0] <= HPI_Q60;
        end else begin
          x[0] <= -in_y;
          y[0] <= in_x;
          acc[0] <= -HPI_Q60;
        end
      end else begin
        x[0] <= in_x;
        y[0] <= in_y;
        acc[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic signed [ACC_W-1:0] ANG = atan_q60(i);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        side[i+1] <= side[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          acc[i+1] <= acc[i] + ANG;
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          acc[i+1] <= acc[i] - ANG;
        end
      end
    end
  end

  assign out_valid = vld[CORDIC_ITERS];
  assign out_acc   = zero[CORDIC_ITERS] ? '0 : acc[CORDIC_ITERS];
  assign out_mag   = zero[CORDIC_ITERS] ? '0 : x[CORDIC_ITERS];
  assign out_side  = side[CORDIC_ITERS];

endmodule

FILE: design/act_units.sv
// radians q60 to 1/64 degree, rounded half away from zero and clamped, two stages
`timescale 1ns / 1ps
module act_units
  import act_pkg::*;
#(
  parameter int SW = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [ACC_W-1:0]   roll_rad,
  input  logic signed [ACC_W-1:0]   pitch_rad,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic signed [ROLL_W-1:0]  roll_angle,
  output logic signed [PITCH_W-1:0] pitch_angle,
  output logic [SW-1:0]             out_side
);

  localparam int QW = ACC_W - 28;
  localparam int NW = QW + 17;
  localparam int DW = 18;

  logic [1:0] vld;
  logic signed [NW-1:0] num [2];
  logic [SW-1:0] side_q;
  logic signed [QW-1:0] q [2];
  logic signed [NW-1:0] mag [2];
  logic [NW:0] rnd [2];
  logic [DW-1:0] n2 [2];
  logic [DW+15:0] prod [2];
  logic [15:0] r [2];
  logic [15:0] rc [2];
  logic signed [16:0] rs [2];

  assign q[0] = QW'(roll_rad >>> 28);
  assign q[1] = QW'(pitch_rad >>> 28);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i]  = (num[i] < 0) ? -num[i] : num[i];
      rnd[i]  = (NW+1)'(mag[i]) + ((NW+1)'(5) << 32);
      n2[i]   = rnd[i][33 +: DW];
      prod[i] = (DW+16)'(n2[i]) * (DW+16)'(DIV5_MUL);
      r[i]    = prod[i][DIV5_SHIFT +: 16];
    end
    rc[0] = (r[0] > 16'(ROLL_LIM)) ? 16'(ROLL_LIM) : r[0];
    rc[1] = (r[1] > 16'(PITCH_LIM)) ? 16'(PITCH_LIM) : r[1];
    for (int i = 0; i < 2; i++) begin
      rs[i] = (num[i] < 0) ? -$signed({1'b0, rc[i]}) : $signed({1'b0, rc[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= NW'(q[0]) * NW'(UNITS_MUL);
      num[1] <= NW'(q[1]) * NW'(UNITS_MUL);
      side_q <= in_side;
      roll_angle <= rs[0][ROLL_W-1:0];
      pitch_angle <= rs[1][PITCH_W-1:0];
      out_side <= side_q;
    end
  end

  assign out_valid = vld[1];

endmodule

FILE: design/accel_calibrate_tilt_unit.sv
// top level: calibration, roll cordic, pitch cordic and angle scaling
//
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       accel_x, accel_y, accel_z
// m_axis    out  m_tvalid / m_tready       cal_x, cal_y, cal_z, roll_angle, pitch_angle
//
// one transaction accepted per cycle while m_axis is not stalled
// the two 40-iteration cordic pipelines set the depth
// rst clears all valid bits; data registers are not reset
// a stall at m_axis freezes every stage; bubbles stay in place while the output waits
`timescale 1ns / 1ps
module accel_calibrate_tilt_unit
  import act_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // accel_x, accel_y, accel_z
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // cal_x, cal_y, cal_z, roll_angle, pitch_angle
  output logic [((3*SAMPLE_BITS+ROLL_W+PITCH_W+7)/8)*8-1:0] m_tdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int XW = SB + PRE_SHIFT + 4;
  localparam int CW = 3 * SB;
  localparam int OW = ((3*SB+ROLL_W+PITCH_W+7)/8)*8;

  logic en;
  logic cal_valid;
  logic signed [SB-1:0] cx, cy, cz;
  logic roll_valid;
  logic signed [ACC_W-1:0] roll_acc;
  logic signed [XW-1:0] roll_mag;
  logic [CW-1:0] roll_side;
  logic g_valid;
  logic signed [XW-1:0] g_mag;
  logic signed [XW-1:0] g_y;
  logic [ACC_W+CW-1:0] g_side;
  logic p_valid;
  logic signed [ACC_W-1:0] pitch_acc;
  logic signed [XW-1:0] p_mag;
  logic [ACC_W+CW-1:0] p_side;
  logic [CW-1:0] out_cal;
  logic signed [ROLL_W-1:0] roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  act_cal #(.SAMPLE_BITS(SB)) u_cal (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .in_x(s_tdata[SB-1:0]), .in_y(s_tdata[2*SB-1:SB]), .in_z(s_tdata[3*SB-1:2*SB]),
    .out_valid(cal_valid), .out_x(cx), .out_y(cy), .out_z(cz)
  );

  act_cordic #(.XW(XW), .SW(CW)) u_roll (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cal_valid),
    .in_x(XW'(cz) <<< PRE_SHIFT), .in_y(XW'(cy) <<< PRE_SHIFT),
    .in_side({cz, cy, cx}),
    .out_valid(roll_valid), .out_acc(roll_acc), .out_mag(roll_mag), .out_side(roll_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= roll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_mag  <= roll_mag;
      g_y    <= -(XW'($signed(roll_side[SB-1:0])) * XW'(GAIN_Q30));
      g_side <= {roll_acc, roll_side};
    end
  end

  act_cordic #(.XW(XW), .SW(ACC_W + CW)) u_pitch (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(g_valid), .in_x(g_mag), .in_y(g_y), .in_side(g_side),
    .out_valid(p_valid), .out_acc(pitch_acc), .out_mag(p_mag), .out_side(p_side)
  );

  act_units #(.SW(CW)) u_units (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p_valid),
    .roll_rad(p_side[ACC_W+CW-1:CW]), .pitch_rad(pitch_acc),
    .in_side(p_side[CW-1:0]),
    .out_valid(m_tvalid), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .out_side(out_cal)
  );

  assign m_tdata = OW'({pitch_angle, roll_angle, out_cal});

  // p_mag is the gained magnitude of the pitch vector, not part of the result
  logic unused_mag;
  assign unused_mag = ^p_mag;

  a_ready : assert property (@(posedge clk) s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");
  a_reset : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_roll : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (roll_angle <= ROLL_W'(ROLL_LIM)) && (roll_angle >= -ROLL_W'(ROLL_LIM)))
    else $error("roll out of range");
  a_pitch : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_angle <= PITCH_W'(PITCH_LIM)) && (pitch_angle >= -PITCH_W'(PITCH_LIM)))
    else $error("pitch out of range");

endmodule

FILE: sim/tb_accel_calibrate_tilt_unit.sv
// testbench for the accelerometer calibration and tilt unit: predictor, random stimulus and checks
`timescale 1ns / 1ps
module tb_accel_calibrate_tilt_unit;
  import act_pkg::*;

  localparam int SB = 16;
  localparam int IN_W = ((3*SB+7)/8)*8;
  localparam int OUT_W = ((3*SB+ROLL_W+PITCH_W+7)/8)*8;
  localparam int N_RANDOM = 1130;
  localparam int LATENCY = 88;

  typedef struct packed {
    logic signed [SB-1:0] cx;
    logic signed [SB-1:0] cy;
    logic signed [SB-1:0] cz;
    logic signed [ROLL_W-1:0] roll;
    logic signed [PITCH_W-1:0] pitch;
  } tilt_t;

  typedef struct {
    logic signed [SB-1:0] ax;
    logic signed [SB-1:0] ay;
    logic signed [SB-1:0] az;
    bit known;
    logic signed [ROLL_W-1:0] roll;
    logic signed [PITCH_W-1:0] pitch;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  tilt_t expected_q[$];
  longint atan_lut[CORDIC_ITERS];
  int mismatches = 0;

  accel_calibrate_tilt_unit #(.SAMPLE_BITS(SB)) i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_angle(longint x, longint y, output longint mag);
    longint acc, t, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = HPI_Q60;
      end else begin
        t = x; x = -y; y = t; acc = -HPI_Q60;
      end
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; acc += atan_lut[i];
      end else begin
        x -= dx; y += dy; acc -= atan_lut[i];
      end
    end
    mag = x;
    return acc;
  endfunction

  function automatic longint rad_to_units(longint rad, longint lim);
    longint q, num, den, r;
    q = fshr(rad, 28);
    num = q * 36672;
    den = longint'(10) <<< 32;
    if (num >= 0) r = (num + den / 2) / den;
    else r = -((-num + den / 2) / den);
    return r > lim ? lim : (r < -lim ? -lim : r);
  endfunction

  function automatic tilt_t predict_tilt(logic signed [SB-1:0] ax, logic signed [SB-1:0] ay,
                                         logic signed [SB-1:0] az);
    longint u[3], c[3], s, mag, unused, rl, pt;
    longint hi, lo;
    tilt_t r;
    hi = (longint'(1) <<< (SB-1)) - 1;
    lo = -hi - 1;
    u[0] = longint'(ax) - BIAS[0];
    u[1] = longint'(ay) - BIAS[1];
    u[2] = longint'(az) - BIAS[2];
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += longint'(MAT[i][j]) * u[j];
      s = fshr(s + 8192, 14);
      c[i] = s > hi ? hi : (s < lo ? lo : s);
    end
    rl = cordic_angle(c[2] <<< PRE_SHIFT, c[1] <<< PRE_SHIFT, mag);
    pt = cordic_angle(mag, -c[0] * longint'(GAIN_Q30), unused);
    r.cx = SB'(c[0]);
    r.cy = SB'(c[1]);
    r.cz = SB'(c[2]);
    r.roll = ROLL_W'(rad_to_units(rl, ROLL_LIM));
    r.pitch = PITCH_W'(rad_to_units(pt, PITCH_LIM));
    return r;
  endfunction

  task automatic send_sample(logic signed [SB-1:0] ax, logic signed [SB-1:0] ay,
                             logic signed [SB-1:0] az);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({az, ay, ax});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(predict_tilt(ax, ay, az));
    @(negedge clk);
  endtask

  // sink side: random stalls and checks
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) m_tready <= 1'b1;
      else if (!m_tready && $urandom_range(0, 2) == 0) m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tilt_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.cx = m_tdata[SB-1:0];
      got.cy = m_tdata[2*SB-1:SB];
      got.cz = m_tdata[3*SB-1:2*SB];
      got.roll = m_tdata[3*SB+ROLL_W-1:3*SB];
      got.pitch = m_tdata[3*SB+ROLL_W+PITCH_W-1:3*SB+ROLL_W];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     exp_r.cx, exp_r.cy, exp_r.cz, exp_r.roll, exp_r.pitch,
                     got.cx, got.cy, got.cz, got.roll, got.pitch);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** accel_calibrate_tilt_unit: FAILED **");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    tilt_t p;
    int v, mode, wait_cnt;
    logic signed [SB-1:0] a[3];
    for (int i = 0; i < CORDIC_ITERS; i++) atan_lut[i] = atan_q60(i);
    // zero vector after bias: raw equals bias, so calibrated is zero and both angles zero
    rows.push_back('{-16'sd28, -16'sd160, -16'sd134, 1, 15'sd0, 14'sd0});
    rows.push_back('{16'sd0, 16'sd0, 16'sd0, 0, 0, 0});
    rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0});
    rows.push_back('{-16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0});
    rows.push_back('{16'sh7fff, -16'sh8000, 16'sh7fff, 0, 0, 0});
    rows.push_back('{-16'sh8000, 16'sh7fff, -16'sh8000, 0, 0, 0});
    rows.push_back('{16'sd0, -16'sd160, -16'sd5000, 0, 0, 0});
    rows.push_back('{16'sd4000, -16'sd160, -16'sd134, 0, 0, 0});
    rows.push_back('{-16'sd4000, -16'sd160, -16'sd134, 0, 0, 0});
    rows.push_back('{16'sd256, 16'sd0, 16'sd256, 0, 0, 0});
    rows.push_back('{-16'sd28, 16'sd3000, -16'sd134, 0, 0, 0});
    rows.push_back('{-16'sd28, -16'sd3000, -16'sd134, 0, 0, 0});
    rows.push_back('{16'sd100, -16'sd200, -16'sd300, 0, 0, 0});
    rows.push_back('{16'sh5555, -16'sh2aab, 16'sh0f0f, 0, 0, 0});
    rows.push_back('{-16'sh5556, 16'sh2aaa, -16'sh0f10, 0, 0, 0});
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.known) begin
        p = predict_tilt(rw.ax, rw.ay, rw.az);
        if (p.roll !== rw.roll || p.pitch !== rw.pitch || p.cx !== 0) begin
          mismatches++;
          $display("zero vector: expected %0d %0d got prediction %0d %0d",
                   rw.roll, rw.pitch, p.roll, p.pitch);
        end
      end
      send_sample(rw.ax, rw.ay, rw.az);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        if (mode < 5) v = $signed($urandom_range(0, 1023)) - 512 + 256 * (k == 2);
        else if (mode < 8) v = $signed($urandom_range(0, 65535)) - 32768;
        else if (mode == 8) v = $urandom_range(0, 1) ? 32767 : -32768;
        else v = -$signed($urandom_range(0, 1) ? (k == 0 ? 28 : k == 1 ? 160 : 134) : 0);
        a[k] = SB'(v);
      end
      send_sample(a[0], a[1], a[2]);
    end
    s_tvalid <= 1'b0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("** accel_calibrate_tilt_unit: PASSED **");
    else
      $display("** accel_calibrate_tilt_unit: FAILED **");
    $finish;
  end

endmodule
